// ===== hdl/qenc_pkg.sv =====
// Shared types, widths and constants for the quadrature encoder velocity estimator.
`timescale 1ns / 1ps

package qenc_pkg;

	localparam int WIDE_BITS_DEF   = 32;
	localparam int NARROW_BITS_DEF = 16;

	localparam int NUM_CH     = 4;
	localparam int CH_W       = 2;
	localparam int CNT_W      = 32;
	localparam int PPR_W      = 16;
	localparam int CIRC_W     = 24;
	localparam int DIR_W      = 4;
	localparam int DT_W       = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// shared multiplier: count magnitude x circumference, or ppr x dt
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// dividend: magnitude (<= 2^31) * circumference (< 2^24) * 1000 (< 2^10)
	localparam int NUM_W = 65;
	// divisor: 4 * ppr (< 2^16) * dt (< 2^24)
	localparam int DEN_W = 42;
	localparam int QUO_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_PPR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CIRC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR  = 2'd2;

	localparam logic [PPR_W-1:0]  PPR_RST  = 16'd500;
	localparam logic [CIRC_W-1:0] CIRC_RST = 24'd314159;
	localparam logic [DIR_W-1:0]  DIR_RST  = 4'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEN,
		ST_FOLD,
		ST_MUL,
		ST_SCALE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic [CNT_W-1:0]        now_m;
		logic signed [CNT_W-1:0] delta;
		logic [CNT_W-1:0]        mag;
		logic                    neg;
	} fold_res_t;

	typedef struct packed {
		logic [QUO_W-1:0] quo;
		logic             ovf;
		logic             busy;
		logic             done;
	} div_stat_t;

endpackage

// ===== hdl/qenc_fold.sv =====
// Wraparound fold, direction correction and clamp of one channel's count change.
`timescale 1ns / 1ps

module qenc_fold #(
	parameter int WIDE_BITS   = qenc_pkg::WIDE_BITS_DEF,
	parameter int NARROW_BITS = qenc_pkg::NARROW_BITS_DEF
) (
	input  logic                         narrow,
	input  logic [qenc_pkg::CNT_W-1:0]   now,
	input  logic [qenc_pkg::CNT_W-1:0]   last,
	input  logic                         negate,
	output qenc_pkg::fold_res_t          res
);

	localparam int DW = qenc_pkg::CNT_W + 2;
	localparam logic [qenc_pkg::CNT_W-1:0] WMASK =
		qenc_pkg::CNT_W'((64'd1 << WIDE_BITS) - 64'd1);
	localparam logic [qenc_pkg::CNT_W-1:0] NMASK =
		qenc_pkg::CNT_W'((64'd1 << NARROW_BITS) - 64'd1);
	localparam logic signed [DW-1:0] WHALF = DW'(64'd1 << (WIDE_BITS - 1));
	localparam logic signed [DW-1:0] NHALF = DW'(64'd1 << (NARROW_BITS - 1));
	localparam logic signed [DW-1:0] POS_LIM = DW'(64'h7FFF_FFFF);
	localparam logic signed [DW-1:0] NEG_LIM = -DW'(64'h8000_0000);

	logic [qenc_pkg::CNT_W-1:0] now_m;
	logic signed [DW-1:0]       half;
	logic signed [DW-1:0]       period;
	logic signed [DW-1:0]       raw;
	logic signed [DW-1:0]       fd;
	logic signed [DW-1:0]       sd;
	logic signed [DW-1:0]       mag_w;

	always_comb begin
		now_m  = now & (narrow ? NMASK : WMASK);
		half   = narrow ? NHALF : WHALF;
		period = half <<< 1;
		raw    = $signed({2'b00, now_m}) - $signed({2'b00, last});
		if (raw > half) begin
			fd = raw - period;
		end else if (raw < -half) begin
			fd = raw + period;
		end else begin
			fd = raw;
		end
		sd = negate ? -fd : fd;
		// only a full half period on a 32-bit counter reaches these
		if (sd > POS_LIM) begin
			sd = POS_LIM;
		end else if (sd < NEG_LIM) begin
			sd = NEG_LIM;
		end
		mag_w     = sd[DW-1] ? -sd : sd;
		res.now_m = now_m;
		res.delta = sd[qenc_pkg::CNT_W-1:0];
		res.mag   = mag_w[qenc_pkg::CNT_W-1:0];
		res.neg   = sd[DW-1];
	end

endmodule

// ===== hdl/qenc_div.sv =====
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
`timescale 1ns / 1ps

module qenc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [qenc_pkg::NUM_W-1:0]  num,
	input  logic [qenc_pkg::DEN_W-1:0]  den,
	output qenc_pkg::div_stat_t         stat
);

	localparam int QW = qenc_pkg::QUO_W;
	localparam int DW = qenc_pkg::DEN_W;
	localparam int CW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] lo_q;
	logic [QW-1:0] quo_q;
	logic          ovf_q;

	logic [DW:0]   trial;
	logic [DW+1:0] diff;
	logic          ge;
	logic [DW:0]   hi_ext;

	always_comb begin
		trial  = {rem_q, lo_q[QW-1]};
		diff   = {1'b0, trial} - (DW + 2)'(den_q);
		ge     = ~diff[DW+1];
		hi_ext = (DW + 1)'(num[qenc_pkg::NUM_W-1:QW]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				done_q <= (cnt_q == '0);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient needs more than QW bits when the high part already holds den
			ovf_q <= hi_ext >= {1'b0, den};
			rem_q <= DW'(num[qenc_pkg::NUM_W-1:QW]);
			lo_q  <= num[QW-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			lo_q  <= {lo_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign stat.quo  = quo_q;
	assign stat.ovf  = ovf_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hdl/quad_encoder_velocity_estimator_top.sv =====
// Top level: sequencer, shared multiplier and state of the encoder velocity estimator.
`timescale 1ns / 1ps

// Four-channel quadrature encoder delta and speed estimator.
// Input channel (in_valid/in_ready): one beat carries four raw counter readings and
// elapsed_us. A beat with elapsed_us of zero is taken and dropped: no result, no state
// change. Output channel (out_valid/out_ready): one beat per useful input beat with the
// four direction-corrected deltas and four speeds in mm/s (truncated, saturated).
// Config port (cfg_we/cfg_index/cfg_data): 0 pulses_per_rev, 1 wheel_circumference_um,
// 2 direction_mask; other indexes are dropped. Write only while idle.
// Steps: one state forms ppr x dt; then, per channel, the fold, multiply, scale and
// divider start states run, followed by the 32-step restoring divider; a final state
// loads the output register, and only then is a new input beat taken.
// in_ready is high only while the sequencer is idle. The result sits in an output
// register, so a stalled receiver holds that beat while the next item is computed;
// that item then waits in the final state until the output register frees up.
// Reset: stored previous counts go to zero, registers to 500 / 314159 / 0, both
// channels empty.
module quad_encoder_velocity_estimator_top #(
	parameter int WIDE_COUNTER_BITS   = qenc_pkg::WIDE_BITS_DEF,
	parameter int NARROW_COUNTER_BITS = qenc_pkg::NARROW_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [qenc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qenc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [31:0]                         count_ch0,
	input  logic [15:0]                         count_ch1,
	input  logic [15:0]                         count_ch2,
	input  logic [31:0]                         count_ch3,
	input  logic [23:0]                         elapsed_us,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [31:0]                  delta_ch0,
	output logic signed [16:0]                  delta_ch1,
	output logic signed [16:0]                  delta_ch2,
	output logic signed [31:0]                  delta_ch3,
	output logic signed [31:0]                  speed_ch0,
	output logic signed [31:0]                  speed_ch1,
	output logic signed [31:0]                  speed_ch2,
	output logic signed [31:0]                  speed_ch3
);

	localparam int NCH = qenc_pkg::NUM_CH;
	localparam int CW  = qenc_pkg::CNT_W;
	localparam int QW  = qenc_pkg::QUO_W;

	qenc_pkg::st_t state_q, state_d;

	logic [qenc_pkg::CH_W-1:0]   ch_q;
	logic [qenc_pkg::PPR_W-1:0]  ppr_q;
	logic [qenc_pkg::CIRC_W-1:0] circ_q;
	logic [qenc_pkg::DIR_W-1:0]  dir_q;
	logic [qenc_pkg::DT_W-1:0]   dt_q;
	logic [CW-1:0]               cnt_in_q [NCH];
	logic [CW-1:0]               prev_q   [NCH];
	logic signed [CW-1:0]        delta_q  [NCH];
	logic signed [QW-1:0]        speed_q  [NCH];
	logic [qenc_pkg::DEN_W-1:0]  den_q;
	logic [CW-1:0]               mag_q;
	logic                        neg_q;
	logic [qenc_pkg::MUL_P_W-1:0] prod_q;
	logic [qenc_pkg::NUM_W-1:0]  num_q;
	logic                        out_valid_q;

	logic                        in_acc;
	logic                        den_sel;
	logic                        fold_we;
	logic                        mul_we;
	logic                        scale_we;
	logic                        div_start;
	logic                        spd_we;
	logic                        out_load;
	logic                        last_ch;

	logic [qenc_pkg::PPR_W-1:0]   ppr_eff;
	logic [qenc_pkg::MUL_A_W-1:0] mul_a;
	logic [qenc_pkg::MUL_B_W-1:0] mul_b;
	logic [qenc_pkg::MUL_P_W-1:0] mul_p;
	logic [qenc_pkg::NUM_W-1:0]   prod_x;
	logic [qenc_pkg::NUM_W-1:0]   scaled;
	logic [QW-1:0]                lim;
	logic [QW-1:0]                smag;
	logic [QW-1:0]                sval;

	qenc_pkg::fold_res_t fold_res;
	qenc_pkg::div_stat_t div_stat;

	// ---------------- sequencer ----------------
	always_comb begin
		last_ch = (ch_q == qenc_pkg::CH_W'(NCH - 1));
		state_d = state_q;
		case (state_q)
			qenc_pkg::ST_IDLE: begin
				if (in_valid && elapsed_us != '0) state_d = qenc_pkg::ST_DEN;
			end
			qenc_pkg::ST_DEN:    state_d = qenc_pkg::ST_FOLD;
			qenc_pkg::ST_FOLD:   state_d = qenc_pkg::ST_MUL;
			qenc_pkg::ST_MUL:    state_d = qenc_pkg::ST_SCALE;
			qenc_pkg::ST_SCALE:  state_d = qenc_pkg::ST_DIV_GO;
			qenc_pkg::ST_DIV_GO: state_d = qenc_pkg::ST_DIV_WAIT;
			qenc_pkg::ST_DIV_WAIT: begin
				if (div_stat.done) state_d = last_ch ? qenc_pkg::ST_OUT : qenc_pkg::ST_FOLD;
			end
			qenc_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = qenc_pkg::ST_IDLE;
			end
			default: state_d = qenc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		den_sel   = 1'b0;
		fold_we   = 1'b0;
		mul_we    = 1'b0;
		scale_we  = 1'b0;
		div_start = 1'b0;
		spd_we    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			qenc_pkg::ST_IDLE:     in_ready  = 1'b1;
			qenc_pkg::ST_DEN:      den_sel   = 1'b1;
			qenc_pkg::ST_FOLD:     fold_we   = 1'b1;
			qenc_pkg::ST_MUL:      mul_we    = 1'b1;
			qenc_pkg::ST_SCALE:    scale_we  = 1'b1;
			qenc_pkg::ST_DIV_GO:   div_start = 1'b1;
			qenc_pkg::ST_DIV_WAIT: spd_we    = div_stat.done;
			qenc_pkg::ST_OUT:      out_load  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qenc_pkg::ST_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			if (den_sel) begin
				ch_q <= '0;
			end else if (spd_we) begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q  <= qenc_pkg::PPR_RST;
			circ_q <= qenc_pkg::CIRC_RST;
			dir_q  <= qenc_pkg::DIR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				qenc_pkg::CFG_PPR:  ppr_q  <= cfg_data[qenc_pkg::PPR_W-1:0];
				qenc_pkg::CFG_CIRC: circ_q <= cfg_data[qenc_pkg::CIRC_W-1:0];
				qenc_pkg::CFG_DIR:  dir_q  <= cfg_data[qenc_pkg::DIR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- input capture and previous counts ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cnt_in_q[0] <= count_ch0;
			cnt_in_q[1] <= CW'(count_ch1);
			cnt_in_q[2] <= CW'(count_ch2);
			cnt_in_q[3] <= count_ch3;
			dt_q        <= elapsed_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) prev_q[i] <= '0;
		end else if (fold_we) begin
			prev_q[ch_q] <= fold_res.now_m;
		end
	end

	qenc_fold #(
		.WIDE_BITS   (WIDE_COUNTER_BITS),
		.NARROW_BITS (NARROW_COUNTER_BITS)
	) u_fold (
		.narrow (ch_q == qenc_pkg::CH_W'(1) || ch_q == qenc_pkg::CH_W'(2)),
		.now    (cnt_in_q[ch_q]),
		.last   (prev_q[ch_q]),
		.negate (dir_q[ch_q]),
		.res    (fold_res)
	);

	// ---------------- shared multiplier and x1000 scaling ----------------
	always_comb begin
		ppr_eff = (ppr_q == '0) ? qenc_pkg::PPR_W'(1) : ppr_q;
		mul_a   = den_sel ? qenc_pkg::MUL_A_W'(ppr_eff) : mag_q;
		mul_b   = den_sel ? dt_q : circ_q;
		mul_p   = qenc_pkg::MUL_P_W'(mul_a) * qenc_pkg::MUL_P_W'(mul_b);
		prod_x  = qenc_pkg::NUM_W'(prod_q);
		scaled  = (prod_x << 10) - (prod_x << 4) - (prod_x << 3);
	end

	always_ff @(posedge clk) begin
		if (den_sel) begin
			den_q <= {mul_p[qenc_pkg::DEN_W-3:0], 2'b00};
		end
		if (fold_we) begin
			delta_q[ch_q] <= fold_res.delta;
			mag_q         <= fold_res.mag;
			neg_q         <= fold_res.neg;
		end
		if (mul_we) begin
			prod_q <= mul_p;
		end
		if (scale_we) begin
			num_q <= scaled;
		end
		if (spd_we) begin
			speed_q[ch_q] <= sval;
		end
	end

	// ---------------- divider and speed saturation ----------------
	qenc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.stat   (div_stat)
	);

	always_comb begin
		lim  = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		smag = (div_stat.ovf || div_stat.quo > lim) ? lim : div_stat.quo;
		sval = neg_q ? (32'd0 - smag) : smag;
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			delta_ch0 <= delta_q[0];
			delta_ch1 <= delta_q[1][16:0];
			delta_ch2 <= delta_q[2][16:0];
			delta_ch3 <= delta_q[3];
			speed_ch0 <= speed_q[0];
			speed_ch1 <= speed_q[1];
			speed_ch2 <= speed_q[2];
			speed_ch3 <= speed_q[3];
		end
	end

	assign out_valid = out_valid_q;

	// ---------------- assertions ----------------
	a_div_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == qenc_pkg::ST_DIV_WAIT)
		else $error("divider busy outside its wait state");

	a_zero_dt_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && elapsed_us == '0 |=> state_q == qenc_pkg::ST_IDLE)
		else $error("zero elapsed time beat started a computation");

	a_narrow_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> delta_ch1 >= -17'sd32768 && delta_ch1 <= 17'sd32768)
		else $error("narrow channel delta out of half-period range");

	a_zero_delta_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && delta_ch0 == '0 |-> speed_ch0 == '0)
		else $error("nonzero speed for zero delta");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the four-channel quadrature encoder delta and speed estimator.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT   = 4000000;
	localparam int SETTLE_CYCLES = 160;
	localparam logic [qenc_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;
	localparam longint POS_LIM = 64'sd2147483647;
	localparam longint NEG_LIM = -64'sd2147483648;

	typedef struct packed {
		logic [3:0][31:0] cnt;
		logic [23:0]      dt;
	} tick_t;

	typedef struct packed {
		logic [3:0][31:0] delta;
		logic [3:0][31:0] speed;
	} motion_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [qenc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [qenc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [31:0] count_ch0;
	logic [15:0] count_ch1;
	logic [15:0] count_ch2;
	logic [31:0] count_ch3;
	logic [23:0] elapsed_us;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] delta_ch0;
	logic signed [16:0] delta_ch1;
	logic signed [16:0] delta_ch2;
	logic signed [31:0] delta_ch3;
	logic signed [31:0] speed_ch0;
	logic signed [31:0] speed_ch1;
	logic signed [31:0] speed_ch2;
	logic signed [31:0] speed_ch3;

	// predictor state
	logic [qenc_pkg::PPR_W-1:0]  ppr_reg;
	logic [qenc_pkg::CIRC_W-1:0] circ_reg;
	logic [qenc_pkg::DIR_W-1:0]  dir_reg;
	logic [31:0]       last_count [qenc_pkg::NUM_CH];
	motion_t           motion_q [$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int err_cnt;
	int cycles;
	int n_ticks;
	int n_dropped;
	int n_checked;
	int n_writes;

	quad_encoder_velocity_estimator_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.count_ch0  (count_ch0),
		.count_ch1  (count_ch1),
		.count_ch2  (count_ch2),
		.count_ch3  (count_ch3),
		.elapsed_us (elapsed_us),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.delta_ch0  (delta_ch0),
		.delta_ch1  (delta_ch1),
		.delta_ch2  (delta_ch2),
		.delta_ch3  (delta_ch3),
		.speed_ch0  (speed_ch0),
		.speed_ch1  (speed_ch1),
		.speed_ch2  (speed_ch2),
		.speed_ch3  (speed_ch3)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				motion_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int chan_bits(input int ch);
		return (ch == 1 || ch == 2) ? qenc_pkg::NARROW_BITS_DEF : qenc_pkg::WIDE_BITS_DEF;
	endfunction

	// mm/s = delta * circ * 1000 / (4 * ppr * dt), truncated toward zero, saturated
	function automatic logic [31:0] linear_speed(input longint d, input logic [63:0] circ,
		input logic [63:0] ppr, input logic [63:0] dt);
		logic neg;
		logic [63:0] mag, lim, den, num, q1, r1, q;
		neg = (d < 0);
		mag = neg ? 64'(-d) : 64'(d);
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		den = 64'd4 * ppr * dt;
		num = mag * circ;
		q1 = num / den;
		r1 = num % den;
		if (q1 > lim) begin
			q = lim;
		end else begin
			q = q1 * 64'd1000 + (r1 * 64'd1000) / den;
			if (q > lim)
				q = lim;
		end
		return neg ? 32'(-q) : q[31:0];
	endfunction

	// Returns 0 for a tick that is dropped (zero elapsed time); state is left alone then.
	function automatic bit predict_motion(input tick_t t, output motion_t m);
		logic [63:0] ppr_eff, now;
		longint period, d;
		m = '0;
		if (t.dt == '0)
			return 1'b0;
		ppr_eff = (ppr_reg == '0) ? 64'd1 : 64'(ppr_reg);
		for (int i = 0; i < qenc_pkg::NUM_CH; i++) begin
			period = 64'sd1 <<< chan_bits(i);
			now = 64'(t.cnt[i]) & (64'(period) - 64'd1);
			d = longint'(now) - longint'(64'(last_count[i]));
			// exactly half a period is kept as is
			if (d > period / 2)
				d -= period;
			if (d < -(period / 2))
				d += period;
			last_count[i] = now[31:0];
			if (dir_reg[i])
				d = -d;
			if (d > POS_LIM)
				d = POS_LIM;
			if (d < NEG_LIM)
				d = NEG_LIM;
			m.delta[i] = (i == 1 || i == 2) ? {15'd0, d[16:0]} : d[31:0];
			m.speed[i] = linear_speed(d, 64'(circ_reg), ppr_eff, 64'(t.dt));
		end
		return 1'b1;
	endfunction

	function automatic tick_t mk_tick(input logic [31:0] c0, input logic [15:0] c1,
		input logic [15:0] c2, input logic [31:0] c3, input logic [23:0] dt);
		tick_t t;
		t.cnt[0] = c0;
		t.cnt[1] = {16'd0, c1};
		t.cnt[2] = {16'd0, c2};
		t.cnt[3] = c3;
		t.dt = dt;
		return t;
	endfunction

	// Mostly plausible encoder motion from the stored counts, some noise and corner values.
	function automatic tick_t make_tick();
		tick_t t;
		int mode, sel;
		int unsigned span;
		longint step, half;
		logic [63:0] mask;
		mode = $urandom_range(0, 99);
		for (int i = 0; i < qenc_pkg::NUM_CH; i++) begin
			half = 64'sd1 <<< (chan_bits(i) - 1);
			mask = (64'd1 << chan_bits(i)) - 64'd1;
			if (mode < 72) begin
				sel = $urandom_range(0, 9);
				span = (sel < 6) ? 64 : (sel < 9) ? 20000 : 32'(half);
				step = longint'($urandom_range(0, span));
				if ($urandom_range(0, 1) == 0)
					step = -step;
			end else if (mode < 88) begin
				step = longint'({$urandom, $urandom});
			end else begin
				case ($urandom_range(0, 5))
					0: step = half;
					1: step = -half;
					2: step = half + 1;
					3: step = -longint'(last_count[i]);
					4: step = -longint'(last_count[i]) - 1;
					default: step = 0;
				endcase
			end
			t.cnt[i] = 32'((64'(last_count[i]) + 64'(step)) & mask);
		end
		if (mode < 72)
			t.dt = 24'($urandom_range(100, 5000));
		else if (mode < 96)
			t.dt = 24'($urandom_range(1, 24'hFFFFFF));
		else if (mode < 98)
			t.dt = ($urandom_range(0, 1) == 0) ? 24'd1 : 24'hFFFFFF;
		else
			t.dt = '0;
		return t;
	endfunction

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		motion_t got, want;
		if (out_valid && out_ready) begin
			got.delta[0] = delta_ch0;
			got.delta[1] = {15'd0, delta_ch1};
			got.delta[2] = {15'd0, delta_ch2};
			got.delta[3] = delta_ch3;
			got.speed[0] = speed_ch0;
			got.speed[1] = speed_ch1;
			got.speed[2] = speed_ch2;
			got.speed[3] = speed_ch3;
			if (motion_q.size() == 0) begin
				err_cnt++;
				$error("Result beat with no tick pending");
			end else begin
				want = motion_q.pop_front();
				n_checked++;
				for (int i = 0; i < qenc_pkg::NUM_CH; i++) begin
					if (got.delta[i] !== want.delta[i]) begin
						err_cnt++;
						$error("delta_ch%0d expected 0x%h actual 0x%h", i,
							want.delta[i], got.delta[i]);
					end
					if (got.speed[i] !== want.speed[i]) begin
						err_cnt++;
						$error("speed_ch%0d expected %0d actual %0d", i,
							$signed(want.speed[i]), $signed(got.speed[i]));
					end
				end
			end
		end
	end

	task automatic send_tick(input tick_t t);
		motion_t m;
		int gap;
		@(negedge clk);
		gap = (send_idle_pct > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(1, 200) : 0;
		while (gap > 0 || $urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
			if (gap > 0)
				gap--;
		end
		in_valid = 1'b1;
		count_ch0 = t.cnt[0];
		count_ch1 = t.cnt[1][15:0];
		count_ch2 = t.cnt[2][15:0];
		count_ch3 = t.cnt[3];
		elapsed_us = t.dt;
		do
			@(posedge clk);
		while (!in_ready);
		n_ticks++;
		if (predict_motion(t, m))
			motion_q.push_back(m);
		else
			n_dropped++;
	endtask

	// Sender pauses until every expected result is in, then lets the block settle.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (motion_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [qenc_pkg::CFG_IDX_W-1:0] idx,
		input logic [qenc_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		n_writes++;
		case (idx)
			qenc_pkg::CFG_PPR:  ppr_reg = data[qenc_pkg::PPR_W-1:0];
			qenc_pkg::CFG_CIRC: circ_reg = data[qenc_pkg::CIRC_W-1:0];
			qenc_pkg::CFG_DIR:  dir_reg = data[qenc_pkg::DIR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_config(input logic [23:0] ppr, input logic [23:0] circ,
		input logic [23:0] dir);
		drain();
		cfg_write(qenc_pkg::CFG_PPR, ppr);
		cfg_write(qenc_pkg::CFG_CIRC, circ);
		cfg_write(qenc_pkg::CFG_DIR, dir);
	endtask

	task automatic pick_config();
		logic [23:0] ppr, circ;
		case ($urandom_range(0, 7))
			0: ppr = 24'd1;
			1: ppr = 24'hFFFF;
			2: ppr = {8'($urandom_range(0, 255)), 16'd0};
			3, 4: ppr = 24'($urandom_range(100, 4096));
			default: ppr = 24'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: circ = 24'd1;
			1: circ = 24'hFFFFFF;
			2: circ = 24'd0;
			3, 4: circ = 24'($urandom_range(50000, 600000));
			default: circ = 24'($urandom);
		endcase
		set_config(ppr, circ, 24'($urandom_range(0, 15)));
	endtask

	task automatic test_wrap_extremes();
		send_tick(mk_tick(32'd0, 16'd0, 16'd0, 32'd0, 24'd1));
		send_tick(mk_tick(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 24'hFFFFFF));
		// minus half a period
		send_tick(mk_tick(32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 32'h7FFFFFFF, 24'd1000));
		// plus half a period, wide channels clamp
		send_tick(mk_tick(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 24'd1000));
		// one short of minus half a period is kept as is, no fold
		send_tick(mk_tick(32'h80000000, 16'h8000, 16'h8000, 32'h80000000, 24'd1));
		send_tick(mk_tick(32'h80000123, 16'h7F00, 16'h8100, 32'h7FFFFF00, 24'd977));
	endtask

	task automatic test_zero_elapsed();
		send_tick(mk_tick($urandom, 16'($urandom), 16'($urandom), $urandom, 24'd0));
		send_tick(mk_tick(32'h80000200, 16'h7F10, 16'h80F0, 32'h7FFFFF10, 24'd1));
		send_tick(mk_tick(32'hDEADBEEF, 16'hBEEF, 16'h1234, 32'h00C0FFEE, 24'd0));
		send_tick(mk_tick(32'h80000100, 16'h7F20, 16'h80E0, 32'h7FFFFF20, 24'd2));
	endtask

	task automatic test_direction();
		set_config(24'd500, 24'd314159, 24'hF);
		send_tick(mk_tick(32'h00000100, 16'hFF20, 16'h00E0, 32'hFFFFFF20, 24'd3));
		// negated minus half clamps on wide channel 3; channel 0 gets negated plus half
		send_tick(mk_tick(32'h80000100, 16'h7F20, 16'h80E0, 32'h7FFFFF20, 24'd3));
		send_tick(mk_tick(32'h00000100, 16'hFF20, 16'h00E0, 32'hFFFFFF20, 24'd3));
		set_config(24'd500, 24'd314159, 24'h5);
		send_tick(mk_tick(32'h00000200, 16'hFF00, 16'h0200, 32'hFFFFFE00, 24'd10));
	endtask

	task automatic test_register_corners();
		// upper data bits dropped: pulses per rev reads as zero
		set_config(24'h5A0000, 24'd0, 24'd0);
		send_tick(mk_tick(32'h00100200, 16'hFE00, 16'h1200, 32'hFF001E00, 24'd10));
		drain();
		cfg_write(CFG_NONE, 24'($urandom));
		cfg_write(qenc_pkg::CFG_CIRC, 24'd1000);
		send_tick(mk_tick(32'h00100300, 16'hFD00, 16'h1300, 32'hFF001D00, 24'd10));
		// speed saturation in both directions
		set_config(24'd1, 24'hFFFFFF, 24'h0);
		send_tick(mk_tick(32'h7F000000, 16'h7000, 16'h9000, 32'h80000000, 24'd1));
		send_tick(mk_tick(32'h00100300, 16'hFD00, 16'h1300, 32'hFF001D00, 24'd1));
		send_tick(mk_tick(32'h00100301, 16'hFD01, 16'h12FF, 32'hFF001D01, 24'd1));
		set_config(24'hFFFF, 24'd1, 24'hA);
		send_tick(mk_tick(32'h00000000, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 24'hFFFFFF));
	endtask

	task automatic test_backpressure();
		set_config(24'd1024, 24'd200000, 24'd0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 3000;
		repeat (12) send_tick(make_tick());
		drain();
	endtask

	task automatic run_traffic(input int n, input int send_pct, input int recv_pct);
		tick_t t;
		int sent;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < n) begin
			if (sent % 120 == 0)
				pick_config();
			t = make_tick();
			send_tick(t);
			if (t.dt != '0)
				sent++;
		end
	endtask

	task automatic test_random_traffic();
		run_traffic(480, 0, 0);
		run_traffic(480, 72, 0);
		run_traffic(480, 0, 72);
		run_traffic(480, 18, 18);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		count_ch0 = '0;
		count_ch1 = '0;
		count_ch2 = '0;
		count_ch3 = '0;
		elapsed_us = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		err_cnt = 0;
		cycles = 0;
		n_ticks = 0;
		n_dropped = 0;
		n_checked = 0;
		n_writes = 0;
		ppr_reg = qenc_pkg::PPR_RST;
		circ_reg = qenc_pkg::CIRC_RST;
		dir_reg = qenc_pkg::DIR_RST;
		for (int i = 0; i < qenc_pkg::NUM_CH; i++)
			last_count[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_wrap_extremes();
		test_zero_elapsed();
		test_direction();
		test_register_corners();
		test_backpressure();
		test_random_traffic();
		drain();

		$display("Sent %0d ticks (%0d with zero elapsed time), checked %0d results,",
			n_ticks, n_dropped, n_checked);
		$display("made %0d register writes under four idle and stall patterns.", n_writes);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/qenc_pkg.sv
hdl/qenc_fold.sv
hdl/qenc_div.sv
hdl/quad_encoder_velocity_estimator_top.sv
bench/testbench.sv
